### design/lscc_pkg.sv
// lscc_pkg: shared constants and types for the laser stripe column centroid block
// no dependencies; imported by laser_stripe_column_centroid
`default_nettype none
package lscc_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	// position counters also reach the two flush positions past the frame edge
	localparam int POS_W = (COL_W > ROW_W ? COL_W : ROW_W) + 1;
	localparam int CNT_W = ROW_W + 1;
	localparam int SUM_W = ROW_W + CNT_W - 1;
	localparam int DIV_IT_W = $clog2(SUM_W + 1);

	localparam int GRAY_W = 8;
	localparam int DIM_W  = 12;
	localparam int CFG_W  = 12;
	localparam int OUT_W  = 11;

	typedef enum logic [1:0] {
		REG_THRESHOLD = 2'd0,
		REG_WIDTH     = 2'd1,
		REG_HEIGHT    = 2'd2
	} reg_idx_t;

	typedef enum logic {
		REQ_PIXEL = 1'b0,
		REQ_DRAIN = 1'b1
	} req_t;

	// flush phase of a frame: real rows, then two empty rows past the bottom
	typedef enum logic [1:0] {
		FL_REAL = 2'd0,
		FL_ONE  = 2'd1,
		FL_TWO  = 2'd2
	} flush_t;

	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_STEP_RD,
		ST_STEP_WR,
		ST_DR_RD,
		ST_DR_LD,
		ST_DR_DIV,
		ST_DR_OUT
	} state_t;

endpackage
`default_nettype wire

### design/laser_stripe_column_centroid.sv
// laser_stripe_column_centroid: top level, binarize, 3x3 closing, column centroids
// depends on lscc_pkg
// pixel: accept, then one memory read step, then one compute and write step;
//   each row adds 2 flush steps, each frame adds 2 flush rows of (width+2) steps
// drain tick: accept, read, load, 22-step restoring divider, output load
// reset: asynchronous, then a clearing pass over all 2048 column
//   accumulators during which no item is taken (config writes still land)
`default_nettype none
module laser_stripe_column_centroid import lscc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// config write port
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_data,
	// input stream
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [7:0]        s_tdata,  // [7:0] gray_value
	input  wire logic              s_tuser,  // [0] req_type
	// result stream
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [23:0]            m_tdata,  // [10:0] column_index, [21:11] center_row, [22] found
	output logic                   m_tlast   // last_column
);

	// config registers
	logic [GRAY_W-1:0] thr_q;
	logic [DIM_W-1:0]  width_q;
	logic [DIM_W-1:0]  height_q;
	logic [POS_W-1:0]  w_eff;
	logic [POS_W-1:0]  h_eff;

	// sequencer
	state_t state_q, state_d;
	logic [COL_W-1:0]  clr_q;
	logic [POS_W-1:0]  vr_q;      // virtual row, runs two past the last real row
	logic [POS_W-1:0]  vc_q;      // virtual column, runs two past the last column
	flush_t            fl_q;
	logic              pix_q;
	logic              fc_q;      // frame complete, drain pending
	logic [COL_W-1:0]  drain_q;

	// sliding windows along the row
	logic vb1_q, vb2_q, ve1_q, ve2_q;

	// line stores: [0] row above, [1] two rows above
	logic [1:0]        bin_mem [MAX_WIDTH];
	logic [1:0]        dil_mem [MAX_WIDTH];
	logic [CNT_W-1:0]  cnt_mem [MAX_WIDTH];
	logic [SUM_W-1:0]  sum_mem [MAX_WIDTH];
	logic [1:0]        bin_rd_q, dil_rd_q;
	logic [CNT_W-1:0]  cnt_rd_q;
	logic [SUM_W-1:0]  sum_rd_q;

	// divider
	logic [SUM_W-1:0]    quo_q;
	logic [CNT_W-1:0]    rem_q;
	logic [CNT_W-1:0]    dvs_q;
	logic [DIV_IT_W-1:0] it_q;
	logic [CNT_W:0]      trial;

	// output register
	logic [COL_W-1:0]  out_col_q;
	logic [OUT_W-1:0]  out_ctr_q;
	logic              out_fnd_q;
	logic              out_last_q;

	logic in_xfer;
	logic out_free;
	logic is_real, in_col, dcol_ok, more_pix, row_end, last_row, drain_last;
	logic b_cur, b_m1, b_m2, vb, d_val, d_cur, d_m2, d_m3, ve_eff, e_bit, acc;
	logic [COL_W-1:0] a_bin, a_dil, a_acc, a_cs;
	logic [POS_W-1:0] vc_m1, vc_m2, vr_m2;

	// clamp dimensions: zero acts as one, oversize acts as the maximum
	always_comb begin
		if (width_q == '0) w_eff = POS_W'(1);
		else if (POS_W'(width_q) > POS_W'(MAX_WIDTH)) w_eff = POS_W'(MAX_WIDTH);
		else w_eff = POS_W'(width_q);
		if (height_q == '0) h_eff = POS_W'(1);
		else if (POS_W'(height_q) > POS_W'(MAX_HEIGHT)) h_eff = POS_W'(MAX_HEIGHT);
		else h_eff = POS_W'(height_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= GRAY_W'(150);
			width_q  <= DIM_W'(MAX_WIDTH);
			height_q <= DIM_W'(MAX_HEIGHT);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_THRESHOLD: thr_q    <= cfg_data[GRAY_W-1:0];
				REG_WIDTH:     width_q  <= cfg_data[DIM_W-1:0];
				REG_HEIGHT:    height_q <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// window step arithmetic, one virtual position per step
	always_comb begin
		vc_m1    = vc_q - POS_W'(1);
		vc_m2    = vc_q - POS_W'(2);
		vr_m2    = vr_q - POS_W'(2);
		is_real  = (fl_q == FL_REAL);
		in_col   = (vc_q < w_eff);
		dcol_ok  = (vc_q >= POS_W'(1)) && (vc_q <= w_eff);
		more_pix = is_real && ((vc_q + POS_W'(1)) < w_eff);
		row_end  = (vc_q == (w_eff + POS_W'(1)));
		last_row = ((vr_q + POS_W'(1)) >= h_eff) || ((vr_q + POS_W'(1)) >= POS_W'(MAX_HEIGHT));

		a_bin = vc_q[COL_W-1:0];
		a_dil = vc_m1[COL_W-1:0];
		a_acc = vc_m2[COL_W-1:0];

		// dilation: vertical or, then horizontal or; rows or columns outside count as clear
		b_cur = is_real && in_col && pix_q;
		b_m1  = in_col && (vr_q >= POS_W'(1)) && bin_rd_q[0];
		b_m2  = in_col && (vr_q >= POS_W'(2)) && bin_rd_q[1];
		vb    = b_cur | b_m1 | b_m2;
		d_val = vb | ((vc_q >= POS_W'(1)) && vb1_q) | ((vc_q >= POS_W'(2)) && vb2_q);

		// erosion: vertical and, then horizontal and; outside counts as set
		d_cur  = (fl_q == FL_TWO) ? 1'b1 : d_val;
		d_m2   = (vr_q >= POS_W'(2)) ? dil_rd_q[0] : 1'b1;
		d_m3   = (vr_q >= POS_W'(3)) ? dil_rd_q[1] : 1'b1;
		ve_eff = (dcol_ok && (vr_q >= POS_W'(2))) ? (d_cur & d_m2 & d_m3) : 1'b1;
		e_bit  = ve_eff & ((vc_q >= POS_W'(2)) ? ve1_q : 1'b1)
		                & ((vc_q >= POS_W'(3)) ? ve2_q : 1'b1);
		acc    = (vr_q >= POS_W'(2)) && (vc_q >= POS_W'(2)) && e_bit;

		drain_last = ((POS_W'(drain_q) + POS_W'(1)) >= w_eff);
		trial      = {rem_q, quo_q[SUM_W-1]} - {1'b0, dvs_q};
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLR:     if (clr_q == COL_W'(MAX_WIDTH - 1)) state_d = ST_IDLE;
			ST_IDLE: begin
				if (in_xfer) begin
					if (s_tuser == REQ_PIXEL && !fc_q) state_d = ST_STEP_RD;
					else if (s_tuser == REQ_DRAIN && fc_q) state_d = ST_DR_RD;
				end
			end
			ST_STEP_RD: state_d = ST_STEP_WR;
			ST_STEP_WR: begin
				if (more_pix) state_d = ST_IDLE;
				else if (!row_end) state_d = ST_STEP_RD;
				else if (is_real) state_d = last_row ? ST_STEP_RD : ST_IDLE;
				else if (fl_q == FL_ONE) state_d = ST_STEP_RD;
				else state_d = ST_IDLE;
			end
			ST_DR_RD:   state_d = ST_DR_LD;
			ST_DR_LD:   state_d = ST_DR_DIV;
			ST_DR_DIV:  if (it_q == '0) state_d = ST_DR_OUT;
			ST_DR_OUT:  state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		out_free = !m_tvalid || m_tready;
		s_tready = (state_q == ST_IDLE) && out_free;
		case (state_q)
			ST_CLR:  a_cs = clr_q;
			ST_DR_RD, ST_DR_LD: a_cs = drain_q;
			default: a_cs = a_acc;
		endcase
	end

	assign in_xfer = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
			vr_q    <= '0;
			vc_q    <= '0;
			fl_q    <= FL_REAL;
			fc_q    <= 1'b0;
			drain_q <= '0;
			it_q    <= '0;
			m_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			case (state_q)
				ST_CLR: clr_q <= clr_q + COL_W'(1);
				ST_STEP_WR: begin
					if (!row_end) begin
						vc_q <= vc_q + POS_W'(1);
					end else begin
						vc_q <= '0;
						if (is_real && !last_row) begin
							vr_q <= vr_q + POS_W'(1);
						end else if (is_real) begin
							vr_q <= vr_q + POS_W'(1);
							fl_q <= FL_ONE;
						end else if (fl_q == FL_ONE) begin
							vr_q <= vr_q + POS_W'(1);
							fl_q <= FL_TWO;
						end else begin
							vr_q <= '0;
							fl_q <= FL_REAL;
							fc_q <= 1'b1;
						end
					end
				end
				ST_DR_LD:  it_q <= DIV_IT_W'(SUM_W - 1);
				ST_DR_DIV: it_q <= it_q - DIV_IT_W'(1);
				ST_DR_OUT: begin
					m_tvalid <= 1'b1;
					if (drain_last) begin
						drain_q <= '0;
						fc_q    <= 1'b0;
					end else begin
						drain_q <= drain_q + COL_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) pix_q <= (s_tdata[GRAY_W-1:0] > thr_q);
		if (state_q == ST_STEP_WR) begin
			vb1_q <= vb;
			vb2_q <= vb1_q;
			ve1_q <= ve_eff;
			ve2_q <= ve1_q;
		end
		case (state_q)
			ST_DR_LD: begin
				quo_q <= sum_rd_q;
				dvs_q <= cnt_rd_q;
				rem_q <= '0;
			end
			ST_DR_DIV: begin
				if (!trial[CNT_W]) begin
					rem_q <= trial[CNT_W-1:0];
					quo_q <= {quo_q[SUM_W-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[CNT_W-2:0], quo_q[SUM_W-1]};
					quo_q <= {quo_q[SUM_W-2:0], 1'b0};
				end
			end
			ST_DR_OUT: begin
				out_col_q  <= drain_q;
				out_fnd_q  <= (dvs_q != '0);
				out_ctr_q  <= (dvs_q != '0) ? quo_q[OUT_W-1:0] : '0;
				out_last_q <= drain_last;
			end
			default: ;
		endcase
	end

	// line stores
	always_ff @(posedge clk) begin
		bin_rd_q <= bin_mem[a_bin];
		dil_rd_q <= dil_mem[a_dil];
		if (state_q == ST_STEP_WR && in_col) bin_mem[a_bin] <= {b_m1, b_cur};
		if (state_q == ST_STEP_WR && dcol_ok) dil_mem[a_dil] <= {dil_rd_q[0], d_val};
	end

	// column accumulators: cleared by the pass after reset and on drain
	always_ff @(posedge clk) begin
		cnt_rd_q <= cnt_mem[a_cs];
		sum_rd_q <= sum_mem[a_cs];
		if (state_q == ST_CLR || state_q == ST_DR_LD) begin
			cnt_mem[a_cs] <= '0;
			sum_mem[a_cs] <= '0;
		end else if (state_q == ST_STEP_WR && acc) begin
			cnt_mem[a_cs] <= cnt_rd_q + CNT_W'(1);
			sum_mem[a_cs] <= sum_rd_q + SUM_W'(vr_m2[ROW_W-1:0]);
		end
	end

	assign m_tdata = {1'b0, out_fnd_q, out_ctr_q, out_col_q};
	assign m_tlast = out_last_q;

	// a result only appears right after the output load step
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == ST_DR_OUT)
		else $error("result raised outside output load");

	// virtual column never runs past the two flush positions
	a_vc_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_STEP_WR |-> vc_q <= w_eff + POS_W'(1))
		else $error("column position out of range");

	// division only runs for a completed frame
	a_div_frame: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DR_DIV |-> fc_q)
		else $error("drain without completed frame");

	// no new item while the output slot is occupied and stalled
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready)
		else $error("input taken while result stalled");

endmodule
`default_nettype wire
